### hw/rtl/aojq_pkg.sv
// ----------------------------------------------------------------------------
// aojq_pkg: shared types and codes for the arrival-ordered job queue
// Beat layouts for both channels, the entry layout, action and status codes,
// and the command bundle that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package aojq_pkg;

  // Field widths fixed by the beat layouts.
  localparam int TIME_W  = 16;
  localparam int PRIO_W  = 4;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  // The removal target is position plus one, so it needs one more bit.
  localparam int TGT_W   = POS_W + 1;

  // Action codes.
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_POP    = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // One stored job.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] service;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Input beat.
  typedef struct packed {
    logic [2:0]        action;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] service_time;
    logic [PRIO_W-1:0] job_priority;
    logic [POS_W-1:0]  position;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic              head_valid;
    logic [TIME_W-1:0] head_arrival;
    logic [TIME_W-1:0] head_service;
    logic [PRIO_W-1:0] head_priority;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]        status;
  } out_beat_t;

  // Command broadcast to every cell. At most one flag is set, only for an accepted
  // command, and insert, append, pop and remove only when they change the queue.
  typedef struct packed {
    logic             ins;
    logic             app;
    logic             pop;
    logic             rem;
    logic             clr;
    entry_t           entry;
    logic [TGT_W-1:0] target;
  } cell_cmd_t;

endpackage

### hw/rtl/aojq_cell.sv
// ----------------------------------------------------------------------------
// aojq_cell: one slot of the job queue chain
// Holds one entry and its occupied flag. Depending on the broadcast command
// it keeps its entry, loads the new job, or takes the entry of its left or
// right neighbor, so the whole chain shifts at once.
// ----------------------------------------------------------------------------
module aojq_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  aojq_pkg::cell_cmd_t cmd,
  input  logic               left_v,
  input  aojq_pkg::entry_t   left_e,
  input  logic               right_v,
  input  aojq_pkg::entry_t   right_e,
  input  logic               found_in,
  output logic               found_out,
  output logic               v_o,
  output aojq_pkg::entry_t   e_o,
  output aojq_pkg::entry_t   e_nxt_o
);

  logic             v_r;
  logic             v_nxt;
  aojq_pkg::entry_t e_r;
  aojq_pkg::entry_t e_nxt;
  logic             later;
  logic             at_or_above;

  // Insert point: first slot that is empty or holds a later arrival.
  assign later     = !v_r || (e_r.arrival > cmd.entry.arrival);
  assign found_out = found_in || later;

  // Slots at or beyond the removal target close the gap.
  assign at_or_above = IDX >= int'(cmd.target);

  // Next slot contents for each operation.
  always_comb begin
    v_nxt = v_r;
    e_nxt = e_r;
    if (cmd.clr) begin
      v_nxt = 1'b0;
    end else if (cmd.ins) begin
      if (found_in) begin
        v_nxt = left_v;
        e_nxt = left_e;
      end else if (later) begin
        v_nxt = 1'b1;
        e_nxt = cmd.entry;
      end
    end else if (cmd.app) begin
      if (!v_r && left_v) begin
        v_nxt = 1'b1;
        e_nxt = cmd.entry;
      end
    end else if (cmd.pop || (cmd.rem && at_or_above)) begin
      v_nxt = right_v;
      e_nxt = right_e;
    end
  end

  // Occupied flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Entry payload needs no reset.
  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  assign v_o     = v_r;
  assign e_o     = e_r;
  assign e_nxt_o = e_nxt;

endmodule

### hw/rtl/arrival_ordered_job_queue_unit.sv
// A result beat is registered and appears the cycle after its input is accepted.
// Throughput: one beat per cycle when not stalled; every operation is a single
// parallel shift of the cell chain; the insert point is a carry passed cell to cell.
// Reset: synchronous, active low; it empties the queue and drops any pending
// result beat. Entry payloads are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// arrival_ordered_job_queue_unit: ordered job queue built as a chain of cells
// Accepts insert, append, pop, remove-after and clear commands and reports
// the head entry, the entry count and a status for every command.
// ----------------------------------------------------------------------------
module arrival_ordered_job_queue_unit #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aojq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aojq_pkg::out_beat_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                 accept;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 full;
  logic                 empty;
  logic                 rem_ok;
  logic [1:0]           status;
  aojq_pkg::cell_cmd_t  cmd;
  logic                 out_valid_r;
  aojq_pkg::out_beat_t  out_data_r;
  aojq_pkg::out_beat_t  result;

  logic                 v_w     [DEPTH];
  aojq_pkg::entry_t     e_w     [DEPTH];
  aojq_pkg::entry_t     e_nxt_w [DEPTH];
  logic                 found_w [DEPTH+1];

  // Take a beat whenever the result register is free or being drained.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full   = count_r == CNT_W'(DEPTH);
  assign empty  = count_r == '0;
  // The entry after the given position exists only below the count.
  assign rem_ok = (int'(in_data.position) + 1) < int'(count_r);

  // Decode the action into a cell command and a status.
  always_comb begin
    cmd        = '0;
    cmd.entry  = '{arrival: in_data.arrival_time,
                   service: in_data.service_time,
                   prio:    in_data.job_priority};
    cmd.target = aojq_pkg::TGT_W'(in_data.position) + 1'b1;
    status     = aojq_pkg::ST_DONE;
    count_nxt  = count_r;
    unique case (in_data.action) inside
      aojq_pkg::ACT_INSERT, aojq_pkg::ACT_APPEND: begin
        if (full) begin
          status = aojq_pkg::ST_FULL;
        end else begin
          cmd.ins   = accept && (in_data.action == aojq_pkg::ACT_INSERT);
          cmd.app   = accept && (in_data.action == aojq_pkg::ACT_APPEND);
          count_nxt = count_r + 1'b1;
        end
      end
      aojq_pkg::ACT_POP: begin
        if (empty) begin
          status = aojq_pkg::ST_NONE;
        end else begin
          cmd.pop   = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      aojq_pkg::ACT_REMOVE: begin
        if (!rem_ok) begin
          status = aojq_pkg::ST_NONE;
        end else begin
          cmd.rem   = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      aojq_pkg::ACT_CLEAR: begin
        cmd.clr   = accept;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Cell chain; the insert-point carry enters at the head as zero.
  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             left_v;
    aojq_pkg::entry_t left_e;
    logic             right_v;
    aojq_pkg::entry_t right_e;

    // The head has no left neighbor; it counts as occupied so an append into
    // an empty queue lands in the head slot.
    if (i == 0) begin : g_head
      assign left_v = 1'b1;
      assign left_e = '0;
    end else begin : g_mid
      assign left_v = v_w[i-1];
      assign left_e = e_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_v = 1'b0;
      assign right_e = '0;
    end else begin : g_body
      assign right_v = v_w[i+1];
      assign right_e = e_w[i+1];
    end

    aojq_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_v    (left_v),
      .left_e    (left_e),
      .right_v   (right_v),
      .right_e   (right_e),
      .found_in  (found_w[i]),
      .found_out (found_w[i+1]),
      .v_o       (v_w[i]),
      .e_o       (e_w[i]),
      .e_nxt_o   (e_nxt_w[i])
    );
  end

  // Result beat reports the queue as it stands after this command.
  always_comb begin
    result               = '0;
    result.head_valid    = count_nxt != '0;
    result.entry_count   = aojq_pkg::COUNT_W'(count_nxt);
    result.status        = status;
    if (result.head_valid) begin
      result.head_arrival  = e_nxt_w[0].arrival;
      result.head_service  = e_nxt_w[0].service;
      result.head_priority = e_nxt_w[0].prio;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sim/aojq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aojq_checker: result predictor and scoreboard for the job queue
// Watches both channels, keeps its own copy of the ordered job store, works out
// the head, count and status that every accepted command beat must produce,
// and compares each accepted result beat with the oldest outstanding report.
// ----------------------------------------------------------------------------
module aojq_checker
  import aojq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending_results,
  output int        beats_seen,
  output int        peak_entries,
  output int        full_drops,
  output int        empty_hits
);

  localparam int MAX_PRINTED = 100;

  // Shadow copy of the queue: slot 0 is the head.
  entry_t    job_slots [DEPTH];
  int        job_total;
  out_beat_t reports_due [$];

  // Prints one line per failure (up to a cap) and counts every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_PRINTED) begin
      $display("check failed at %0t ns: %s: got %0h, expected %0h",
               $time, what, got, want);
    end
    fail_count++;
  endtask

  // Applies one command to the shadow queue and builds the report it causes.
  task automatic advance_job_queue(input in_beat_t cmd, output out_beat_t rpt);
    entry_t     job;
    int         open_at;
    int         close_at;
    int         slot;
    logic [1:0] st;
    job.arrival = cmd.arrival_time;
    job.service = cmd.service_time;
    job.prio    = cmd.job_priority;
    open_at     = -1;
    close_at    = -1;
    st          = ST_DONE;
    case (cmd.action)
      ACT_INSERT: begin
        if (job_total >= DEPTH) begin
          st = ST_FULL;
        end else begin
          // Step past every entry that arrived no later, so ties keep order.
          open_at = 0;
          while (open_at < job_total && job_slots[open_at].arrival <= job.arrival)
            open_at++;
        end
      end
      ACT_APPEND: begin
        if (job_total >= DEPTH) st = ST_FULL;
        else open_at = job_total;
      end
      ACT_POP: begin
        if (job_total == 0) st = ST_NONE;
        else close_at = 0;
      end
      ACT_REMOVE: begin
        if (int'(cmd.position) + 1 >= job_total) st = ST_NONE;
        else close_at = int'(cmd.position) + 1;
      end
      ACT_CLEAR: begin
        job_total = 0;
      end
      default: begin
      end
    endcase

    // Open a slot by shifting the tail up one place.
    if (open_at >= 0) begin
      for (slot = job_total; slot > open_at; slot--)
        job_slots[slot] = job_slots[slot-1];
      job_slots[open_at] = job;
      job_total++;
    end

    // Close a slot by shifting the tail down one place.
    if (close_at >= 0) begin
      for (slot = close_at; slot + 1 < job_total; slot++)
        job_slots[slot] = job_slots[slot+1];
      job_total--;
    end

    rpt = '0;
    if (job_total > 0) begin
      rpt.head_valid    = 1'b1;
      rpt.head_arrival  = job_slots[0].arrival;
      rpt.head_service  = job_slots[0].service;
      rpt.head_priority = job_slots[0].prio;
    end
    rpt.entry_count = COUNT_W'(job_total);
    rpt.status      = st;
  endtask

  // Result beats are matched before the same edge's command beat is added,
  // since a result can only belong to an earlier command.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      job_total = 0;
      reports_due.delete();
      pending_results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          report_mismatch("result beat with no command outstanding", 32'd1, 32'd0);
        end else begin
          want = reports_due.pop_front();
          if (out_data.head_valid !== want.head_valid)
            report_mismatch("head_valid", 32'(out_data.head_valid),
                            32'(want.head_valid));
          if (out_data.head_arrival !== want.head_arrival)
            report_mismatch("head_arrival", 32'(out_data.head_arrival),
                            32'(want.head_arrival));
          if (out_data.head_service !== want.head_service)
            report_mismatch("head_service", 32'(out_data.head_service),
                            32'(want.head_service));
          if (out_data.head_priority !== want.head_priority)
            report_mismatch("head_priority", 32'(out_data.head_priority),
                            32'(want.head_priority));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_data.entry_count),
                            32'(want.entry_count));
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
      end
      if (in_valid && !in_stall) begin
        advance_job_queue(in_data, want);
        reports_due.push_back(want);
        beats_seen++;
        if (job_total > peak_entries) peak_entries = job_total;
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_NONE) empty_hits++;
      end
      pending_results = reports_due.size();
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the arrival-ordered job queue
// Drives a short directed sequence and then phases of random commands that
// fill, drain and churn the queue, with random idle bursts on both channels,
// one long result hold-off and one full drain pause. The checker beside the
// block predicts every result beat and counts failures.
// ----------------------------------------------------------------------------
module tb_top;
  import aojq_pkg::*;

  localparam int DEPTH           = 64;
  localparam int RANDOM_ITEMS    = 1250;
  localparam int QUIET_TAIL      = 150;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int HOLD_OFF_PHASE  = 3;
  localparam int RUN_LIMIT_NS    = 3_000_000;

  // Command mixes for the random phases.
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_CHURN = 2;

  // Action codes the block leaves unused.
  localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [2:0] ACT_SPARE_MID = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  // Receiver controls.
  logic      idle_on;
  logic      hold_off_req;

  int fail_count;
  int pending_results;
  int beats_seen;
  int peak_entries;
  int full_drops;
  int empty_hits;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arrival_ordered_job_queue_unit #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  aojq_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .beats_seen     (beats_seen),
    .peak_entries   (peak_entries),
    .full_drops     (full_drops),
    .empty_hits     (empty_hits)
  );

  // Result side: random stall bursts, plus one long hold-off on request. Stall
  // changes only at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_beat_t job_cmd(input logic [2:0] action,
                                       input logic [TIME_W-1:0] arrival,
                                       input logic [TIME_W-1:0] service,
                                       input logic [PRIO_W-1:0] prio,
                                       input logic [POS_W-1:0] position);
    in_beat_t cmd;
    cmd.action       = action;
    cmd.arrival_time = arrival;
    cmd.service_time = service;
    cmd.job_priority = prio;
    cmd.position     = position;
    return cmd;
  endfunction

  // Random command; the mix sets how strongly it grows or shrinks the queue.
  function automatic in_beat_t random_command(input int mix);
    in_beat_t cmd;
    int       roll;
    int       pick;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 60) cmd.action = ACT_INSERT;
        else if (roll < 95) cmd.action = ACT_APPEND;
        else if (roll < 98) cmd.action = ACT_POP;
        else cmd.action = ACT_REMOVE;
      end
      MIX_DRAIN: begin
        if (roll < 15) cmd.action = ACT_INSERT;
        else if (roll < 25) cmd.action = ACT_APPEND;
        else if (roll < 60) cmd.action = ACT_POP;
        else if (roll < 98) cmd.action = ACT_REMOVE;
        else cmd.action = ACT_CLEAR;
      end
      default: begin
        if (roll < 35) cmd.action = ACT_INSERT;
        else if (roll < 50) cmd.action = ACT_APPEND;
        else if (roll < 70) cmd.action = ACT_POP;
        else if (roll < 90) cmd.action = ACT_REMOVE;
        else if (roll < 92) cmd.action = ACT_CLEAR;
        else if (roll < 93) cmd.action = ACT_SPARE_LO;
        else if (roll < 94) cmd.action = ACT_SPARE_MID;
        else if (roll < 95) cmd.action = ACT_SPARE_HI;
        else cmd.action = ACT_INSERT;
      end
    endcase

    // Narrow key ranges make equal arrival times common.
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd.arrival_time = $urandom;
    else if (pick < 80) cmd.arrival_time = $urandom_range(0, 15);
    else if (pick < 90) cmd.arrival_time = '0;
    else cmd.arrival_time = '1;
    cmd.service_time = $urandom;
    cmd.job_priority = $urandom;

    // Positions lean toward the head and toward the top of a full queue.
    pick = $urandom_range(0, 99);
    if (pick < 50) cmd.position = $urandom_range(0, 7);
    else if (pick < 80) cmd.position = $urandom;
    else cmd.position = $urandom_range(56, 63);
    return cmd;
  endfunction

  // Offers one command beat, maybe after an idle burst, and returns at the
  // falling edge after it has been taken.
  task automatic offer_command(input in_beat_t cmd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drops valid and waits until every outstanding result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  initial begin
    int random_done;
    int phase;
    int phase_len;
    int mix;
    int n;
    in_beat_t cmd;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    random_done  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-queue corner cases first.
    offer_command(job_cmd(ACT_CLEAR, 16'h0000, 16'h0000, 4'h0, 6'd0));
    offer_command(job_cmd(ACT_POP, 16'h0000, 16'h0000, 4'h0, 6'd0));
    offer_command(job_cmd(ACT_REMOVE, 16'h0000, 16'h0000, 4'h0, 6'd0));
    offer_command(job_cmd(ACT_SPARE_LO, 16'h1234, 16'h5678, 4'h9, 6'd1));
    // Sorted inserts with a tie, a new head and a new tail.
    offer_command(job_cmd(ACT_INSERT, 16'd100, 16'h0000, 4'h0, 6'd0));
    offer_command(job_cmd(ACT_INSERT, 16'd100, 16'hFFFF, 4'hF, 6'd63));
    offer_command(job_cmd(ACT_INSERT, 16'h0000, 16'h0001, 4'h1, 6'd0));
    offer_command(job_cmd(ACT_INSERT, 16'hFFFF, 16'h0002, 4'h2, 6'd0));
    // Append ignores ordering; a later tie lands behind the first zero key.
    offer_command(job_cmd(ACT_APPEND, 16'h0000, 16'h0003, 4'h3, 6'd0));
    offer_command(job_cmd(ACT_INSERT, 16'h0000, 16'hAAAA, 4'h5, 6'h2A));
    // Remove-after: a real successor, a position far past the count, and
    // the last entry through its predecessor.
    offer_command(job_cmd(ACT_REMOVE, 16'hFFFF, 16'hFFFF, 4'hF, 6'd0));
    offer_command(job_cmd(ACT_REMOVE, 16'h0000, 16'h0000, 4'h0, 6'd63));
    offer_command(job_cmd(ACT_REMOVE, 16'h0000, 16'h0000, 4'h0, 6'd4));
    offer_command(job_cmd(ACT_REMOVE, 16'h0000, 16'h0000, 4'h0, 6'd3));
    offer_command(job_cmd(ACT_POP, 16'h5555, 16'h5555, 4'hA, 6'h15));
    offer_command(job_cmd(ACT_SPARE_MID, 16'hFFFF, 16'hFFFF, 4'hF, 6'd63));
    offer_command(job_cmd(ACT_SPARE_HI, 16'h0000, 16'h0000, 4'h0, 6'd0));
    offer_command(job_cmd(ACT_INSERT, 16'h8001, 16'h5555, 4'h8, 6'h3F));
    // Clear a populated queue, then touch the empty one again.
    offer_command(job_cmd(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 4'hF, 6'd63));
    offer_command(job_cmd(ACT_POP, 16'h0000, 16'h0000, 4'h0, 6'd0));
    offer_command(job_cmd(ACT_APPEND, 16'hFFFF, 16'hFFFF, 4'hF, 6'd63));
    offer_command(job_cmd(ACT_APPEND, 16'h0000, 16'h0000, 4'h0, 6'd0));

    // Random phases; the first one overfills the queue so full drops occur.
    phase = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (phase == 0) begin
        mix       = MIX_FILL;
        phase_len = 90;
      end else begin
        n = $urandom_range(0, 99);
        mix = (n < 35) ? MIX_FILL : (n < 65) ? MIX_DRAIN : MIX_CHURN;
        phase_len = $urandom_range(40, 120);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      if (random_done >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      // One long hold on the result side while commands keep coming.
      if (phase == HOLD_OFF_PHASE) hold_off_req = 1'b1;

      for (n = 0; n < phase_len && random_done < RANDOM_ITEMS; n++) begin
        if (random_done >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
        cmd = random_command(mix);
        offer_command(cmd);
        if (cmd.action <= ACT_CLEAR) random_done++;
      end

      if (phase == HOLD_OFF_PHASE) wait_for_drain();
      phase++;
    end

    // Let the last results come back, then leave time for strays.
    wait_for_drain();
    repeat (8) @(negedge clk);

    $display("Covered %0d command beats over %0d phases; the queue peaked at %0d of %0d.",
             beats_seen, phase, peak_entries, DEPTH);
    $display("Saw %0d jobs dropped on a full queue and %0d pops or removals with nothing to take.",
             full_drops, empty_hits);
    if (fail_count == 0 && pending_results == 0) begin
      $display("arrival_ordered_job_queue_unit: match");
    end else begin
      $display("arrival_ordered_job_queue_unit: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("arrival_ordered_job_queue_unit: mismatch");
    $finish;
  end

endmodule
